// File: rtl/ssww_pkg.sv
// ----------------------------------------------------------------------------
// ssww_pkg
// Shared types, constants and byte helpers for the whole-word substring search.
// ----------------------------------------------------------------------------
package ssww_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int PIDX_W      = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 7;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // request opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_TEXT  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHOLE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [BYTE_W-1:0] byte_value;
    logic [PIDX_W-1:0] pattern_index;
    logic              has_context;
    logic              last_byte;
  } ssww_in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } ssww_out_t;

  // pattern store write from a load request
  typedef struct packed {
    logic              en;
    logic [PIDX_W-1:0] idx;
    logic [BYTE_W-1:0] data;
  } pat_wr_t;

  // write into the aligned pattern copy held by the cells
  typedef struct packed {
    logic              en;
    logic [PIDX_W-1:0] idx;
    logic [BYTE_W-1:0] data;
  } qwr_t;

  typedef struct packed {
    logic eq;  // window byte matches, or cell beyond pattern length
    logic bw;  // this cell holds the byte before the window and it is a word char
  } cell_res_t;

  // request moving from the cell row to the decision stage
  typedef struct packed {
    logic                   is_text;
    logic [BYTE_W-1:0]      byte_value;
    logic                   last_byte;
    logic                   win_ok;
    logic                   start_zero;
    logic [POS_W-1:0]       start;
    logic                   ctx_word;
    logic [MAX_PATTERN-1:0] eq_vec;
    logic [MAX_PATTERN-1:0] bw_vec;
  } pipe_t;

  function automatic logic is_word(input logic [BYTE_W-1:0] b);
    logic nw;
    nw = (b == 8'h00) ||
         (b >= 8'h20 && b <= 8'h2F) ||
         (b >= 8'h3A && b <= 8'h40) ||
         (b >= 8'h5B && b <= 8'h5E) ||
         (b == 8'h60) ||
         (b >= 8'h7B && b <= 8'h7E);
    return !nw;
  endfunction

  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b,
                                             input logic case_sens);
    logic [BYTE_W-1:0] r;
    r = b;
    if (!case_sens && b >= 8'h61 && b <= 8'h7A) begin
      r = b - 8'd32;
    end
    return r;
  endfunction

endpackage

// File: rtl/substring_search_whole_word.sv
// ----------------------------------------------------------------------------
// substring_search_whole_word
// Leftmost whole-word pattern search over a streamed text region.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | op, byte, pattern index, flags
//  out_    | output    | out_valid/out_stall| found, position
//  cfg_    | input     | cfg_we             | index, 32-bit data
//
//  One request per cycle unless in_stall; pipe and output are registered.
//  A row of 64 cells shifts each text byte and compares the whole window at
//  once; a decision stage then applies the word-boundary rules.
//  Writing pattern_length starts a realign sweep that reads the pattern
//  store once per cycle; in_stall stays high during it.
//  rst_n (synchronous) clears settings, region state and the output.
//  While out_stall holds a result, a request due to emit waits in the pipe.
// ----------------------------------------------------------------------------
module substring_search_whole_word (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ssww_pkg::ssww_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ssww_pkg::ssww_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [ssww_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssww_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssww_pkg::*;

  logic [LEN_W-1:0] len_r;
  logic             case_r;
  logic             whole_r;
  logic [POS_W-1:0] offset_r;
  logic [POS_W-1:0] seen_r;
  logic             ctx_word_r;
  logic             p_valid_r;
  pipe_t            p_r;

  logic             acc;
  logic             is_text;
  logic             is_begin;
  logic             shift_en;
  logic             busy;
  logic             p_take;
  logic [POS_W-1:0] seen_nxt;
  logic [POS_W-1:0] len_ext;
  logic             len_ok;
  pat_wr_t          pat_wr;
  qwr_t             qwr;

  logic [BYTE_W-1:0]      cell_byte [MAX_PATTERN];
  cell_res_t              cell_res  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq_vec;
  logic [MAX_PATTERN-1:0] bw_vec;

  assign in_stall = busy || (p_valid_r && !p_take);
  assign acc      = in_valid && !in_stall;
  assign is_text  = in_data.op == OP_TEXT;
  assign is_begin = in_data.op == OP_BEGIN;
  assign shift_en = acc && is_text;

  assign seen_nxt = seen_r + 32'd1;
  assign len_ext  = {{(POS_W-LEN_W){1'b0}}, len_r};
  assign len_ok   = (len_r != '0) && (len_r <= LEN_W'(MAX_PATTERN));

  assign pat_wr.en   = acc && (in_data.op == OP_LOAD);
  assign pat_wr.idx  = in_data.pattern_index;
  assign pat_wr.data = in_data.byte_value;

  ssww_loader u_loader (
    .clk    (clk),
    .rst_n  (rst_n),
    .len    (len_r),
    .len_wr (cfg_we && cfg_index == CFG_LEN),
    .pat_wr (pat_wr),
    .busy   (busy),
    .qwr    (qwr)
  );

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [BYTE_W-1:0] feed;
    if (j == 0) begin : g_head
      assign feed = in_data.byte_value;
    end else begin : g_body
      assign feed = cell_byte[j-1];
    end

    ssww_cell u_cell (
      .clk       (clk),
      .cell_idx  (PIDX_W'(j)),
      .shift_en  (shift_en),
      .byte_in   (feed),
      .byte_out  (cell_byte[j]),
      .len       (len_r),
      .case_sens (case_r),
      .qwr       (qwr),
      .res       (cell_res[j])
    );

    assign eq_vec[j] = cell_res[j].eq;
    assign bw_vec[j] = cell_res[j].bw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      case_r     <= 1'b0;
      whole_r    <= 1'b0;
      offset_r   <= '0;
      seen_r     <= '0;
      ctx_word_r <= 1'b0;
      p_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LEN:    len_r    <= cfg_data[LEN_W-1:0];
          CFG_CASE:   case_r   <= cfg_data[0];
          CFG_WHOLE:  whole_r  <= cfg_data[0];
          CFG_OFFSET: offset_r <= cfg_data[POS_W-1:0];
        endcase
      end
      if (shift_en) begin
        seen_r <= seen_nxt;
      end else if (acc && is_begin) begin
        seen_r     <= '0;
        ctx_word_r <= in_data.has_context && is_word(in_data.byte_value);
      end
      if (acc && (is_text || is_begin)) begin
        p_valid_r <= 1'b1;
      end else if (p_take) begin
        p_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_r.is_text    <= is_text;
      p_r.byte_value <= in_data.byte_value;
      p_r.last_byte  <= in_data.last_byte;
      p_r.win_ok     <= len_ok && (seen_nxt >= len_ext);
      p_r.start_zero <= seen_nxt == len_ext;
      p_r.start      <= seen_nxt - len_ext;
      p_r.ctx_word   <= ctx_word_r;
      p_r.eq_vec     <= eq_vec;
      p_r.bw_vec     <= bw_vec;
    end
  end

  ssww_decide u_decide (
    .clk          (clk),
    .rst_n        (rst_n),
    .p_valid      (p_valid_r),
    .p            (p_r),
    .whole_words  (whole_r),
    .start_offset (offset_r),
    .p_take       (p_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

// File: rtl/ssww_cell.sv
// ----------------------------------------------------------------------------
// ssww_cell
// One window position: holds a text byte and the aligned pattern byte.
// ----------------------------------------------------------------------------
module ssww_cell (
  input  logic                       clk,
  input  logic [ssww_pkg::PIDX_W-1:0] cell_idx,
  input  logic                       shift_en,
  input  logic [ssww_pkg::BYTE_W-1:0] byte_in,
  output logic [ssww_pkg::BYTE_W-1:0] byte_out,
  input  logic [ssww_pkg::LEN_W-1:0]  len,
  input  logic                       case_sens,
  input  ssww_pkg::qwr_t             qwr,
  output ssww_pkg::cell_res_t        res
);
  import ssww_pkg::*;

  logic [BYTE_W-1:0] text_r;
  logic [BYTE_W-1:0] pat_r;
  logic [LEN_W-1:0]  idx_ext;

  assign idx_ext  = {1'b0, cell_idx};
  assign byte_out = text_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      text_r <= byte_in;
    end
    if (qwr.en && qwr.idx == cell_idx) begin
      pat_r <= qwr.data;
    end
  end

  // compare the byte that enters this cell on the shift
  assign res.eq = (idx_ext >= len) ||
                  (fold(byte_in, case_sens) == fold(pat_r, case_sens));
  // after the shift this byte sits one past the window
  assign res.bw = ((idx_ext + 7'd1) == len) && is_word(text_r);

endmodule

// File: rtl/ssww_loader.sv
// ----------------------------------------------------------------------------
// ssww_loader
// Pattern store and the sweep that realigns the cells' pattern copy.
// ----------------------------------------------------------------------------
module ssww_loader (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ssww_pkg::LEN_W-1:0]  len,
  input  logic                       len_wr,
  input  ssww_pkg::pat_wr_t          pat_wr,
  output logic                       busy,
  output ssww_pkg::qwr_t             qwr
);
  import ssww_pkg::*;

  logic [BYTE_W-1:0] mem [MAX_PATTERN];
  logic [BYTE_W-1:0] rdata_r;
  logic [LEN_W-1:0]  cnt_r;
  logic [PIDX_W-1:0] rd_idx_r;
  logic              rd_valid_r;
  logic              busy_r;
  logic              issue;
  logic [LEN_W-1:0]  rd_addr_full;
  logic [LEN_W-1:0]  wr_pos_full;
  logic              wr_hit;

  assign busy  = busy_r;
  assign issue = busy_r && (cnt_r < LEN_W'(MAX_PATTERN));

  // cell j compares against pattern[len-1-j]
  assign rd_addr_full = len - 7'd1 - cnt_r;
  assign wr_pos_full  = len - 7'd1 - {1'b0, pat_wr.idx};
  assign wr_hit       = pat_wr.en && ({1'b0, pat_wr.idx} < len) &&
                        (len <= LEN_W'(MAX_PATTERN));

  always_ff @(posedge clk) begin
    if (pat_wr.en) begin
      mem[pat_wr.idx] <= pat_wr.data;
    end
    if (issue) begin
      rdata_r  <= mem[rd_addr_full[PIDX_W-1:0]];
      rd_idx_r <= cnt_r[PIDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      cnt_r      <= '0;
      rd_valid_r <= 1'b0;
    end else if (len_wr) begin
      busy_r     <= 1'b1;
      cnt_r      <= '0;
      rd_valid_r <= 1'b0;
    end else if (busy_r) begin
      rd_valid_r <= issue;
      if (issue) begin
        cnt_r <= cnt_r + 7'd1;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    if (rd_valid_r) begin
      qwr.en   = 1'b1;
      qwr.idx  = rd_idx_r;
      qwr.data = rdata_r;
    end else begin
      qwr.en   = wr_hit;
      qwr.idx  = wr_pos_full[PIDX_W-1:0];
      qwr.data = pat_wr.data;
    end
  end

endmodule

// File: rtl/ssww_decide.sv
// ----------------------------------------------------------------------------
// ssww_decide
// Whole-word checks, pending match, region end and the result register.
// ----------------------------------------------------------------------------
module ssww_decide (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       p_valid,
  input  ssww_pkg::pipe_t            p,
  input  logic                       whole_words,
  input  logic [ssww_pkg::POS_W-1:0]  start_offset,
  output logic                       p_take,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ssww_pkg::ssww_out_t        out_data
);
  import ssww_pkg::*;

  logic             pending_r;
  logic [POS_W-1:0] pend_start_r;
  logic             done_r;
  logic             out_valid_r;
  ssww_out_t        out_r;

  logic             text;
  logic             pend_hit;
  logic             full;
  logic             bword;
  logic             pass;
  logic             hit_now;
  logic             found;
  logic             emit;
  logic             out_free;
  logic [POS_W-1:0] emit_start;

  assign text     = p_valid && p.is_text && !done_r;
  assign pend_hit = pending_r && (!whole_words || !is_word(p.byte_value));
  assign full     = p.win_ok && (&p.eq_vec);
  assign bword    = p.start_zero ? p.ctx_word : (|p.bw_vec);
  assign pass     = full && (!whole_words || !bword);
  assign hit_now  = pass && (p.last_byte || !whole_words);
  assign found    = pend_hit || hit_now;
  assign emit     = text && (found || p.last_byte);
  assign emit_start = pend_hit ? pend_start_r : p.start;

  assign out_free = !out_valid_r || !out_stall;
  assign p_take   = p_valid && (out_free || !emit);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (p_take && !p.is_text) begin
        pending_r <= 1'b0;
        done_r    <= 1'b0;
      end else if (p_take && text) begin
        if (emit) begin
          done_r    <= 1'b1;
          pending_r <= 1'b0;
        end else begin
          // a failed pending match drops; a new one may take its place
          pending_r <= pass;
        end
      end
      if (p_take && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_take && text && !emit && pass) begin
      pend_start_r <= p.start;
    end
    if (p_take && emit) begin
      out_r.found    <= found;
      out_r.position <= found ? (start_offset + emit_start) : '0;
    end
  end

endmodule

// File: tb/ssww_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// ssww_scoreboard_pkg
// Result prediction and checking for the whole-word substring search.
//
// The scoreboard keeps its own copy of the pattern, the recent text bytes and
// the register settings. Each accepted request is stepped through that copy,
// and any result it produces is queued. Results from the block are compared
// in order against the queue, one field at a time.
// ----------------------------------------------------------------------------
package ssww_scoreboard_pkg;
  import ssww_pkg::*;

  // opcode the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class search_scoreboard;
    logic [7:0]  pat_bytes [MAX_PATTERN];
    logic [7:0]  history [MAX_PATTERN+1];
    logic [31:0] byte_count;
    bit          ctx_word;
    bit          hold_valid;
    logic [31:0] hold_start;
    bit          region_closed;
    int unsigned pat_len;
    bit          exact_case;
    bit          whole_words;
    logic [31:0] base_pos;
    ssww_out_t   expected_hits [$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
      foreach (history[i]) history[i] = 8'h00;
      byte_count    = '0;
      ctx_word      = 1'b0;
      hold_valid    = 1'b0;
      hold_start    = '0;
      region_closed = 1'b0;
      pat_len       = 0;
      exact_case    = 1'b0;
      whole_words   = 1'b0;
      base_pos      = '0;
      mismatches    = 0;
      results_seen  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LEN:    pat_len = val[6:0];
        CFG_CASE:   exact_case = val[0];
        CFG_WHOLE:  whole_words = val[0];
        CFG_OFFSET: base_pos = val;
        default: ;
      endcase
    endfunction

    // only space, NUL and ASCII punctuation but underscore are non-word bytes
    function bit word_char(logic [7:0] b);
      if (b == 8'h00) return 1'b0;
      if (b >= 8'h20 && b <= 8'h2F) return 1'b0;
      if (b >= 8'h3A && b <= 8'h40) return 1'b0;
      if ((b >= 8'h5B && b <= 8'h5E) || b == 8'h60) return 1'b0;
      if (b >= 8'h7B && b <= 8'h7E) return 1'b0;
      return 1'b1;
    endfunction

    function logic [7:0] fold_byte(logic [7:0] b);
      if (!exact_case && b >= 8'h61 && b <= 8'h7A) return b - 8'd32;
      return b;
    endfunction

    function bit window_hit(int unsigned len);
      int unsigned k;
      for (k = 0; k < len; k++) begin
        if (fold_byte(history[len-1-k]) != fold_byte(pat_bytes[k])) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit close_region(bit hit, logic [31:0] start, output ssww_out_t res);
      res.found    = hit;
      res.position = hit ? base_pos + start : '0;
      region_closed = 1'b1;
      hold_valid    = 1'b0;
      return 1'b1;
    endfunction

    // advance the search by one request; returns 1 when a result is due
    function bit step(ssww_in_t r, output ssww_out_t res);
      int unsigned len;
      int          k;
      logic [31:0] start;
      bit          before_word;
      res = '0;
      len = pat_len;
      case (r.op)
        OP_LOAD: begin
          pat_bytes[r.pattern_index] = r.byte_value;
          return 1'b0;
        end
        OP_BEGIN: begin
          foreach (history[i]) history[i] = 8'h00;
          byte_count    = '0;
          ctx_word      = r.has_context && word_char(r.byte_value);
          hold_valid    = 1'b0;
          hold_start    = '0;
          region_closed = 1'b0;
          return 1'b0;
        end
        OP_TEXT: ;
        default: return 1'b0;
      endcase
      if (region_closed) return 1'b0;

      // a held match is settled by the byte that follows it
      if (hold_valid) begin
        if (!whole_words || !word_char(r.byte_value))
          return close_region(1'b1, hold_start, res);
        hold_valid = 1'b0;
      end

      for (k = MAX_PATTERN; k > 0; k--) history[k] = history[k-1];
      history[0] = r.byte_value;
      byte_count = byte_count + 1;

      if (len > 0 && len <= MAX_PATTERN && byte_count >= len && window_hit(len)) begin
        start = byte_count - len;
        before_word = (start == 0) ? ctx_word : word_char(history[len]);
        if (!whole_words || !before_word) begin
          if (r.last_byte || !whole_words) return close_region(1'b1, start, res);
          hold_valid = 1'b1;
          hold_start = start;
        end
      end

      if (r.last_byte) return close_region(1'b0, '0, res);
      return 1'b0;
    endfunction

    function void note_request(ssww_in_t r);
      ssww_out_t res;
      if (step(r, res)) expected_hits.push_back(res);
    endfunction

    function void flag_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] result %0d: %s", $time, results_seen, what);
    endfunction

    function void check_result(ssww_out_t got);
      ssww_out_t want;
      results_seen++;
      if (expected_hits.size() == 0) begin
        flag_mismatch($sformatf("unexpected, got found=%0b position=%h",
                                got.found, got.position));
        return;
      end
      want = expected_hits.pop_front();
      if (got.found !== want.found)
        flag_mismatch($sformatf("found: expected %0b, actual %0b", want.found, got.found));
      if (got.position !== want.position)
        flag_mismatch($sformatf("position: expected %h, actual %h",
                                want.position, got.position));
    endfunction

    function int unsigned pending();
      return expected_hits.size();
    endfunction

    function int unsigned total_failures();
      if (expected_hits.size() != 0)
        $display("%0d expected results never arrived", expected_hits.size());
      return mismatches + expected_hits.size();
    endfunction
  endclass

endpackage

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the whole-word substring search.
//
// After reset the pattern store is filled, then a directed run covers region
// start, held matches, case folding, word boundaries, position wrap and the
// ignored opcode. Random phases follow with fresh register settings, mostly a
// new pattern, feeding regions built of pattern copies, separators and noise.
// Both channels idle in random bursts; once the receiver holds off for a long
// stretch so the block backs up. The scoreboard checks every result in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssww_pkg::*;
  import ssww_scoreboard_pkg::*;

  localparam int SETTLE_CYCLES  = 6;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int CALM_AFTER     = 1000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  ssww_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  ssww_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  search_scoreboard sb;
  bit               calm        = 1'b0;
  bit               squeeze_req = 1'b0;
  bit               stall_on    = 1'b1;
  int unsigned      gap_pct     = 0;
  int unsigned      items_sent  = 0;
  int unsigned      cur_len     = 0;
  logic [7:0]       pattern_image [MAX_PATTERN];

  substring_search_whole_word dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid === 1'b1 && in_stall === 1'b0) sb.note_request(in_data);
      if (out_valid === 1'b1 && out_stall === 1'b0) sb.check_result(out_data);
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (squeeze_req) begin
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_req = 1'b0;
      end else if (calm || !stall_on || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic offer(input ssww_in_t r);
    if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (r.op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_load(input logic [5:0] idx, input logic [7:0] b);
    pattern_image[idx] = b;
    offer('{op: OP_LOAD, byte_value: b, pattern_index: idx,
            has_context: 1'($urandom), last_byte: 1'($urandom)});
  endtask

  task automatic send_begin(input bit ctx, input logic [7:0] b);
    offer('{op: OP_BEGIN, byte_value: b, pattern_index: 6'($urandom),
            has_context: ctx, last_byte: 1'($urandom)});
  endtask

  task automatic send_text(input logic [7:0] b, input bit last);
    offer('{op: OP_TEXT, byte_value: b, pattern_index: 6'($urandom),
            has_context: 1'($urandom), last_byte: last});
  endtask

  // hold inputs quiet until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // length goes last: its write starts the realign sweep
  task automatic apply_settings(input int unsigned len, input bit exact, input bit whole,
                                input logic [31:0] base);
    logic [CFG_IDX_W-1:0]  regs [4] = '{CFG_CASE, CFG_WHOLE, CFG_OFFSET, CFG_LEN};
    logic [CFG_DATA_W-1:0] vals [4];
    int i;
    vals = '{32'(exact), 32'(whole), base, 32'(len)};
    cfg_we <= 1'b1;
    for (i = 0; i < 4; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_we  <= 1'b0;
    cur_len = len;
  endtask

  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(8'h61, 8'h7A));
      4, 5, 6:    return 8'($urandom_range(8'h41, 8'h5A));
      7:          return 8'($urandom_range(8'h30, 8'h39));
      8:          return 8'h5F;
      default:    return ($urandom_range(0, 1) != 0) ? 8'h09 : 8'($urandom_range(8'h80, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] gap_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h20;
      1:       return 8'h00;
      2:       return 8'($urandom_range(8'h21, 8'h2F));
      3:       return 8'($urandom_range(8'h3A, 8'h40));
      4:       return ($urandom_range(0, 4) == 0) ? 8'h60 : 8'($urandom_range(8'h5B, 8'h5E));
      default: return 8'($urandom_range(8'h7B, 8'h7E));
    endcase
  endfunction

  function automatic logic [7:0] shuffle_case(input logic [7:0] b);
    if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(0, 5) == 0)
      return b ^ 8'h20;
    return b;
  endfunction

  task automatic run_region();
    logic [7:0]  txt [$];
    int unsigned i, n, k, top;
    bit          cut;
    if ($urandom_range(0, 19) != 0) begin
      case ($urandom_range(0, 3))
        0:       send_begin(1'b0, 8'($urandom));
        1:       send_begin(1'b1, word_byte());
        2:       send_begin(1'b1, gap_byte());
        default: send_begin(1'b1, 8'($urandom));
      endcase
    end
    top = (cur_len < MAX_PATTERN) ? cur_len : MAX_PATTERN;
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 5))
        0, 1: for (k = 0; k < top; k++) txt.push_back(shuffle_case(pattern_image[k]));
        2: begin
          n = (top > 1) ? $urandom_range(1, top - 1) : top;
          for (k = 0; k < n; k++) txt.push_back(pattern_image[k]);
        end
        3: repeat ($urandom_range(1, 2)) txt.push_back(gap_byte());
        4: repeat ($urandom_range(1, 4)) txt.push_back(word_byte());
        default: repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom));
      endcase
    end
    if (txt.size() == 0) txt.push_back(8'($urandom));
    // now and then drop the tail so the region is left open
    cut = ($urandom_range(0, 19) == 0);
    n = cut ? $urandom_range(0, txt.size() - 1) : txt.size();
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 49))
        0: offer('{op: OP_UNUSED, byte_value: 8'($urandom), pattern_index: 6'($urandom),
                   has_context: 1'($urandom), last_byte: 1'($urandom)});
        1: send_load(6'($urandom), word_byte());
        default: ;
      endcase
      send_text(txt[i], !cut && i == n - 1);
    end
  endtask

  initial begin
    int unsigned phase, stop_at, calm_at, len, r, i, wait_cycles;
    bit          exact, whole;
    logic [31:0] base;

    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole store so no unwritten entry is ever compared
    for (i = 0; i < MAX_PATTERN; i++) begin
      case (i)
        0:       send_load(6'(i), "a");
        1:       send_load(6'(i), "B");
        2:       send_load(6'(i), "c");
        62:      send_load(6'(i), 8'h00);
        63:      send_load(6'(i), 8'hFF);
        default: send_load(6'(i), 8'($urandom));
      endcase
    end
    drain();
    apply_settings(3, 1'b0, 1'b1, 32'hFFFF_FFFE);

    // region still open from reset; the match at its start waits for the space
    send_text("A", 1'b0);
    send_text("b", 1'b0);
    send_text("C", 1'b0);
    send_text(" ", 1'b0);
    send_text("x", 1'b1);
    offer('{op: OP_UNUSED, byte_value: 8'hFF, pattern_index: 6'h3F,
            has_context: 1'b1, last_byte: 1'b1});
    // word context rejects the first copy; the second ends the region and wraps
    send_begin(1'b1, "z");
    send_text("a", 1'b0);
    send_text("b", 1'b0);
    send_text("c", 1'b0);
    send_text(8'h00, 1'b0);
    send_text("a", 1'b0);
    send_text("b", 1'b0);
    send_text("C", 1'b1);
    // NUL context passes, tab after the match fails it
    send_begin(1'b1, 8'h00);
    send_text("a", 1'b0);
    send_text("B", 1'b0);
    send_text("c", 1'b0);
    send_text(8'h09, 1'b0);
    send_text(8'hFF, 1'b1);
    drain();

    stop_at = items_sent + RANDOM_ITEMS;
    calm_at = items_sent + CALM_AFTER;
    phase   = 0;
    while (items_sent < stop_at) begin
      exact = 1'($urandom);
      whole = 1'($urandom);
      case ($urandom_range(0, 3))
        0:       base = '0;
        1:       base = 32'hFFFF_FFFF;
        2:       base = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        default: base = $urandom;
      endcase
      r = $urandom_range(0, 99);
      if (r < 65)      len = $urandom_range(1, 6);
      else if (r < 85) len = $urandom_range(7, 16);
      else if (r < 93) len = $urandom_range(17, 64);
      else if (r < 97) len = 0;
      else             len = $urandom_range(65, 127);
      case (phase)
        0: begin len = 1;   exact = 1'b0; whole = 1'b1; base = '0; end
        1: begin len = 64;  exact = 1'b1; whole = 1'b0; base = 32'hFFFF_FFFF; end
        2: begin len = 2;   exact = 1'b0; whole = 1'b0; end
        3: begin len = 0;   exact = 1'b1; whole = 1'b1; end
        4: len = 127;
        5: len = 65;
        default: ;
      endcase
      apply_settings(len, exact, whole, base);

      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 35;
      endcase
      stall_on = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        gap_pct     = 0;
        squeeze_req = 1'b1;
      end

      if ($urandom_range(0, 3) != 0) begin
        for (i = 0; i < len && i < MAX_PATTERN; i++) begin
          if ($urandom_range(0, 4) == 0) send_load(6'(i), 8'($urandom));
          else                           send_load(6'(i), word_byte());
        end
      end

      repeat ($urandom_range(2, 6)) begin
        if (items_sent >= calm_at) calm = 1'b1;
        run_region();
      end
      drain();
      phase++;
    end

    calm = 1'b1;
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.total_failures() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ssww_pkg.sv
rtl/ssww_cell.sv
rtl/ssww_loader.sv
rtl/ssww_decide.sv
rtl/substring_search_whole_word.sv
tb/ssww_scoreboard_pkg.sv
tb/tb.sv
